[src/bsml_pkg.sv]
// Shared types, constants and helpers for the battery sample monitor log.
// Used by every module of the block; has no dependencies of its own.
package bsml_pkg;

	// field widths
	localparam int PCT_W    = 7;
	localparam int RAW_W    = 8;
	localparam int VOLT_W   = 16;
	localparam int TIME_W   = 32;
	localparam int IDX_W    = 7;
	localparam int THR_W    = 7;
	localparam int PERIOD_W = 24;
	localparam int MODE_W   = 2;
	localparam int COUNT_W  = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int ENTRY_W  = TIME_W + 1 + PCT_W;

	// default log depth
	localparam int LOG_DEPTH_DEF = 128;

	// largest valid percent
	localparam logic [RAW_W-1:0] PCT_MAX = RAW_W'(100);

	// largest value log_count can show
	localparam int COUNT_MAX = 255;

	// action codes
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_READ   = 1'b1;

	// mode codes
	localparam logic [MODE_W-1:0] MODE_NORMAL    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOW_POWER = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CHARGING  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THR_NORMAL    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THR_LOW_POWER = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THR_CHARGING  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PER_NORMAL    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PER_LOW_POWER = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PER_CHARGING  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL     = 3'd6;

	// configuration reset values
	localparam logic [THR_W-1:0]    RST_THR_NORMAL    = 7'd1;
	localparam logic [THR_W-1:0]    RST_THR_LOW_POWER = 7'd2;
	localparam logic [THR_W-1:0]    RST_THR_CHARGING  = 7'd1;
	localparam logic [PERIOD_W-1:0] RST_PER_NORMAL    = 24'd60000;
	localparam logic [PERIOD_W-1:0] RST_PER_LOW_POWER = 24'd300000;
	localparam logic [PERIOD_W-1:0] RST_PER_CHARGING  = 24'd5000;
	localparam logic [PCT_W-1:0]    RST_LOW_LEVEL     = 7'd20;

	// configuration register contents
	typedef struct packed {
		logic [THR_W-1:0]    thr_normal;
		logic [THR_W-1:0]    thr_low_power;
		logic [THR_W-1:0]    thr_charging;
		logic [PERIOD_W-1:0] period_normal_ms;
		logic [PERIOD_W-1:0] period_low_power_ms;
		logic [PERIOD_W-1:0] period_charging_ms;
		logic [PCT_W-1:0]    low_level_percent;
	} cfg_t;

	// request from the state stage to the log
	typedef struct packed {
		logic              advance;
		logic              sample;
		logic              read;
		logic [PCT_W-1:0]  percent;
		logic              charging;
		logic [TIME_W-1:0] stamp;
		logic [IDX_W-1:0]  index;
	} log_req_t;

	// registered read answer of the log
	typedef struct packed {
		logic              hit;
		logic [PCT_W-1:0]  percent;
		logic              charging;
		logic [TIME_W-1:0] stamp;
	} log_rsp_t;

	// notify threshold of a mode
	function automatic logic [THR_W-1:0] mode_threshold(input cfg_t cfg,
			input logic [MODE_W-1:0] m);
		logic [THR_W-1:0] thr;
		case (m)
			MODE_CHARGING:  thr = cfg.thr_charging;
			MODE_LOW_POWER: thr = cfg.thr_low_power;
			default:        thr = cfg.thr_normal;
		endcase
		return thr;
	endfunction

	// report interval of a mode
	function automatic logic [PERIOD_W-1:0] mode_period(input cfg_t cfg,
			input logic [MODE_W-1:0] m);
		logic [PERIOD_W-1:0] per;
		case (m)
			MODE_CHARGING:  per = cfg.period_charging_ms;
			MODE_LOW_POWER: per = cfg.period_low_power_ms;
			default:        per = cfg.period_normal_ms;
		endcase
		return per;
	endfunction

endpackage

[src/bsml_cfg.sv]
// Configuration register file: thresholds, report intervals, low level.
// Depends on bsml_pkg.
module bsml_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bsml_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bsml_pkg::CFG_DATA_W-1:0] cfg_data,
	output bsml_pkg::cfg_t                  cfg
);
	import bsml_pkg::*;

	cfg_t cfg_q;

	// writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// register write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr_normal          <= RST_THR_NORMAL;
			cfg_q.thr_low_power       <= RST_THR_LOW_POWER;
			cfg_q.thr_charging        <= RST_THR_CHARGING;
			cfg_q.period_normal_ms    <= RST_PER_NORMAL;
			cfg_q.period_low_power_ms <= RST_PER_LOW_POWER;
			cfg_q.period_charging_ms  <= RST_PER_CHARGING;
			cfg_q.low_level_percent   <= RST_LOW_LEVEL;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_THR_NORMAL:    cfg_q.thr_normal          <= cfg_data[THR_W-1:0];
				REG_THR_LOW_POWER: cfg_q.thr_low_power       <= cfg_data[THR_W-1:0];
				REG_THR_CHARGING:  cfg_q.thr_charging        <= cfg_data[THR_W-1:0];
				REG_PER_NORMAL:    cfg_q.period_normal_ms    <= cfg_data[PERIOD_W-1:0];
				REG_PER_LOW_POWER: cfg_q.period_low_power_ms <= cfg_data[PERIOD_W-1:0];
				REG_PER_CHARGING:  cfg_q.period_charging_ms  <= cfg_data[PERIOD_W-1:0];
				REG_LOW_LEVEL:     cfg_q.low_level_percent   <= cfg_data[PCT_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

[src/bsml_log.sv]
// Ring log of percent/charging changes with age-indexed reads.
// Holds the entry memory, write pointer, fill count and newest-entry copy.
// Depends on bsml_pkg.
module bsml_log #(
	parameter int LOG_DEPTH = bsml_pkg::LOG_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bsml_pkg::log_req_t           req,
	output bsml_pkg::log_rsp_t           rsp,
	output logic [bsml_pkg::COUNT_W-1:0] count
);
	import bsml_pkg::*;

	localparam int PW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
	localparam int FW = $clog2(LOG_DEPTH + 1);
	localparam int AW = ((PW > IDX_W) ? PW : IDX_W) + 1;
	localparam int CW = (FW > COUNT_W) ? FW : COUNT_W;

	logic [ENTRY_W-1:0] mem [LOG_DEPTH];

	logic [PW-1:0]    wr_ptr_q;
	logic [FW-1:0]    fill_q;
	logic [PCT_W-1:0] newest_pct_q;
	logic             newest_chg_q;

	logic               hit_s2;
	logic [ENTRY_W-1:0] entry_s2;

	logic          same_as_newest;
	logic          do_write;
	logic          full;
	logic [AW-1:0] oldest;
	logic [AW-1:0] slot_sum;
	logic [AW-1:0] slot_wrap;
	logic [PW-1:0] rd_slot;
	logic          idx_hit;
	logic [CW-1:0] fill_x;

	// append only when the sample differs from the newest entry
	assign same_as_newest = (fill_q != '0) && (newest_pct_q == req.percent)
		&& (newest_chg_q == req.charging);
	assign do_write = req.advance && req.sample && !same_as_newest;

	// oldest entry sits at slot 0 until the ring is full, then at the write pointer
	assign full     = (fill_q == FW'(LOG_DEPTH));
	assign oldest   = full ? AW'(wr_ptr_q) : '0;
	assign slot_sum = oldest + AW'(req.index);
	assign slot_wrap = (slot_sum >= AW'(LOG_DEPTH)) ? slot_sum - AW'(LOG_DEPTH) : slot_sum;
	assign rd_slot  = slot_wrap[PW-1:0];
	assign idx_hit  = req.read && (AW'(req.index) < AW'(fill_q));

	// pointer, fill count and newest entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q     <= '0;
			fill_q       <= '0;
			newest_pct_q <= '0;
			newest_chg_q <= 1'b0;
		end else if (do_write) begin
			wr_ptr_q     <= (wr_ptr_q == PW'(LOG_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (!full)
				fill_q <= fill_q + 1'b1;
			newest_pct_q <= req.percent;
			newest_chg_q <= req.charging;
		end
	end

	// entry memory write port
	always_ff @(posedge clk) begin
		if (do_write)
			mem[wr_ptr_q] <= {req.stamp, req.charging, req.percent};
	end

	// entry memory read port, held while the result waits
	always_ff @(posedge clk) begin
		if (req.advance)
			entry_s2 <= mem[rd_slot];
	end

	// hit flag of the registered read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hit_s2 <= 1'b0;
		else if (req.advance)
			hit_s2 <= idx_hit;
	end

	// read answer, zero on a miss
	always_comb begin
		rsp.hit      = hit_s2;
		rsp.percent  = hit_s2 ? entry_s2[PCT_W-1:0] : '0;
		rsp.charging = hit_s2 ? entry_s2[PCT_W] : 1'b0;
		rsp.stamp    = hit_s2 ? entry_s2[ENTRY_W-1:PCT_W+1] : '0;
	end

	// saturated entry count
	assign fill_x = CW'(fill_q);
	assign count  = (fill_x > CW'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX) : fill_x[COUNT_W-1:0];

endmodule

[src/battery_sample_monitor_log.sv]
// Battery sample monitor with a ring change log.
// A request taken is held in the input register, and its result then in the result register.
// One request per cycle is taken while out_stall does not hold a result back (in_stall).
// Reset: asynchronous, clears mode, previous-sample state, log pointer and fill count;
// log memory contents are left as they are and are only read once written.
// Depends on bsml_pkg, bsml_cfg and bsml_log.
module battery_sample_monitor_log #(
	parameter int LOG_DEPTH = bsml_pkg::LOG_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bsml_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bsml_pkg::CFG_DATA_W-1:0]      cfg_data,
	// request channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 action,
	input  logic signed [bsml_pkg::RAW_W-1:0]    sample_percent,
	input  logic                                 sample_charging,
	input  logic signed [bsml_pkg::VOLT_W-1:0]   sample_voltage_mv,
	input  logic [bsml_pkg::TIME_W-1:0]          sample_time,
	input  logic [bsml_pkg::IDX_W-1:0]           history_index,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 accepted,
	output logic                                 notify,
	output logic [bsml_pkg::MODE_W-1:0]          mode,
	output logic [bsml_pkg::PERIOD_W-1:0]        report_period_ms,
	output logic signed [bsml_pkg::RAW_W-1:0]    state_percent,
	output logic signed [bsml_pkg::VOLT_W-1:0]   state_voltage,
	output logic                                 state_charging,
	output logic [bsml_pkg::COUNT_W-1:0]         log_count,
	output logic                                 log_hit,
	output logic [bsml_pkg::PCT_W-1:0]           log_percent,
	output logic                                 log_charging,
	output logic [bsml_pkg::TIME_W-1:0]          log_time
);
	import bsml_pkg::*;

	cfg_t     cfg;
	log_req_t log_req;
	log_rsp_t log_rsp;

	// input register
	logic              valid_s1;
	logic              action_s1;
	logic [RAW_W-1:0]  pct_s1;
	logic              chg_s1;
	logic [VOLT_W-1:0] volt_s1;
	logic [TIME_W-1:0] time_s1;
	logic [IDX_W-1:0]  idx_s1;

	// result register
	logic                valid_s2;
	logic                accepted_s2;
	logic                notify_s2;
	logic [MODE_W-1:0]   mode_s2;
	logic [PERIOD_W-1:0] period_s2;
	logic [RAW_W-1:0]    state_pct_s2;
	logic [VOLT_W-1:0]   state_volt_s2;
	logic                state_chg_s2;

	// monitor state
	logic [MODE_W-1:0] cur_mode_q;
	logic              prev_seen_q;
	logic [PCT_W-1:0]  prev_pct_q;
	logic              prev_chg_q;
	logic [VOLT_W-1:0] held_volt_q;

	logic              s2_load;
	logic              s1_move;
	logic              in_take;
	logic              sample_ok;
	logic [PCT_W-1:0]  pct7;
	logic [MODE_W-1:0] sel_mode;
	logic [PCT_W-1:0]  diff;
	logic              notify_c;
	logic [MODE_W-1:0] mode_next;
	logic              seen_next;
	logic [PCT_W-1:0]  pct_next;
	logic              chg_next;
	logic [VOLT_W-1:0] volt_next;

	bsml_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// handshake between the stages
	assign s2_load  = !valid_s2 || !out_stall;
	assign s1_move  = valid_s1 && s2_load;
	assign in_stall = valid_s1 && !s2_load;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_take)
			valid_s1 <= 1'b1;
		else if (s1_move)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			action_s1 <= action;
			pct_s1    <= sample_percent;
			chg_s1    <= sample_charging;
			volt_s1   <= sample_voltage_mv;
			time_s1   <= sample_time;
			idx_s1    <= history_index;
		end
	end

	// sample check, mode choice and change detection
	assign sample_ok = (action_s1 == ACT_SAMPLE) && (pct_s1 <= PCT_MAX);
	assign pct7      = pct_s1[PCT_W-1:0];

	always_comb begin
		if (chg_s1)
			sel_mode = MODE_CHARGING;
		else if (pct7 <= cfg.low_level_percent)
			sel_mode = MODE_LOW_POWER;
		else
			sel_mode = MODE_NORMAL;
	end

	assign diff     = (pct7 >= prev_pct_q) ? pct7 - prev_pct_q : prev_pct_q - pct7;
	assign notify_c = sample_ok && prev_seen_q
		&& ((diff >= mode_threshold(cfg, sel_mode)) || (chg_s1 != prev_chg_q));

	// state after this request
	assign mode_next = sample_ok ? sel_mode : cur_mode_q;
	assign seen_next = sample_ok || prev_seen_q;
	assign pct_next  = sample_ok ? pct7 : prev_pct_q;
	assign chg_next  = sample_ok ? chg_s1 : prev_chg_q;
	assign volt_next = sample_ok ? volt_s1 : held_volt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mode_q  <= MODE_NORMAL;
			prev_seen_q <= 1'b0;
			prev_pct_q  <= '0;
			prev_chg_q  <= 1'b0;
			held_volt_q <= '0;
		end else if (s1_move) begin
			cur_mode_q  <= mode_next;
			prev_seen_q <= seen_next;
			prev_pct_q  <= pct_next;
			prev_chg_q  <= chg_next;
			held_volt_q <= volt_next;
		end
	end

	// log request
	always_comb begin
		log_req.advance  = s1_move;
		log_req.sample   = sample_ok;
		log_req.read     = (action_s1 == ACT_READ);
		log_req.percent  = pct7;
		log_req.charging = chg_s1;
		log_req.stamp    = time_s1;
		log_req.index    = idx_s1;
	end

	bsml_log #(
		.LOG_DEPTH (LOG_DEPTH)
	) u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (log_req),
		.rsp    (log_rsp),
		.count  (log_count)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (s2_load)
			valid_s2 <= s1_move;
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			accepted_s2   <= sample_ok;
			notify_s2     <= notify_c;
			mode_s2       <= mode_next;
			period_s2     <= mode_period(cfg, mode_next);
			state_pct_s2  <= seen_next ? {1'b0, pct_next} : '1;
			state_volt_s2 <= seen_next ? volt_next : '1;
			state_chg_s2  <= seen_next && chg_next;
		end
	end

	// result ports
	assign out_valid        = valid_s2;
	assign accepted         = accepted_s2;
	assign notify           = notify_s2;
	assign mode             = mode_s2;
	assign report_period_ms = period_s2;
	assign state_percent    = state_pct_s2;
	assign state_voltage    = state_volt_s2;
	assign state_charging   = state_chg_s2;
	assign log_hit          = log_rsp.hit;
	assign log_percent      = log_rsp.percent;
	assign log_charging     = log_rsp.charging;
	assign log_time         = log_rsp.stamp;

endmodule
